// ===== rtl/core/x86_integer_alu_with_flags_core_assert.svh =====
// Assertion macros used by the integer ALU core module.
// Depends on nothing; included inside module bodies.
`ifndef X86_INTEGER_ALU_WITH_FLAGS_CORE_ASSERT_SVH
`define X86_INTEGER_ALU_WITH_FLAGS_CORE_ASSERT_SVH
// Implication checked every clock edge outside reset.
`define XALU_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define XALU_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/xalu_pkg.sv =====
// Package for the integer ALU core: word types, command codes, flag layout.
// Depends on nothing.
package xalu_pkg;
  localparam int WORD_BITS = 32;

  localparam logic [3:0] CMD_ADD = 4'd0;
  localparam logic [3:0] CMD_SUB = 4'd1;
  localparam logic [3:0] CMD_CMP = 4'd2;
  localparam logic [3:0] CMD_INC = 4'd3;
  localparam logic [3:0] CMD_DEC = 4'd4;
  localparam logic [3:0] CMD_NEG = 4'd5;
  localparam logic [3:0] CMD_ADC = 4'd6;
  localparam logic [3:0] CMD_SBB = 4'd7;
  localparam logic [3:0] CMD_MUL = 4'd8;
  localparam logic [3:0] CMD_IMUL1 = 4'd9;
  localparam logic [3:0] CMD_IMULT = 4'd10;
  localparam logic [3:0] CMD_DIV = 4'd11;
  localparam logic [3:0] CMD_IDIV = 4'd12;

  localparam logic [1:0] SIZE_BYTE  = 2'd0;
  localparam logic [1:0] SIZE_WORD  = 2'd1;
  localparam logic [1:0] SIZE_DWORD = 2'd2;
  // Spare size code; behaves as doubleword.
  localparam logic [1:0] SIZE_RSVD  = 2'd3;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [1:0]  size_code;
    logic [31:0] dest_value;
    logic [31:0] src_value;
    logic [31:0] acc_low;
    logic [31:0] acc_high;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_low;
    logic [31:0] result_high;
    logic        write_back;
    logic        high_valid;
    logic        carry_flag;
    logic        zero_flag;
    logic        sign_flag;
    logic        overflow_flag;
    logic        divide_fault;
  } out_word_t;

  // Operand width mask for a size code; code three means doubleword.
  function automatic logic [31:0] size_mask(input logic [1:0] sz);
    unique case (sz)
      SIZE_BYTE: size_mask = 32'h0000_00FF;
      SIZE_WORD: size_mask = 32'h0000_FFFF;
      default:   size_mask = 32'hFFFF_FFFF;
    endcase
  endfunction

  // Sign bit of a value at operand size.
  function automatic logic size_msb(input logic [31:0] v, input logic [1:0] sz);
    unique case (sz)
      SIZE_BYTE: size_msb = v[7];
      SIZE_WORD: size_msb = v[15];
      default:   size_msb = v[31];
    endcase
  endfunction
endpackage

// ===== rtl/core/xalu_divider.sv =====
// Unsigned 64-by-32 restoring divider, one quotient bit per cycle.
// Stand-alone; uses no package.
module xalu_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] numer,
  input  logic [31:0] denom,
  output logic        busy,
  output logic        done,
  output logic [63:0] quot,
  output logic [31:0] rem
);
  logic [63:0] q;
  logic [32:0] r;
  logic [31:0] dv;
  logic [6:0]  count;
  logic [32:0] shifted;
  logic [33:0] diff;

  // One shift-and-subtract step on the subtractor.
  always_comb begin
    shifted = {r[31:0], q[63]};
    diff    = {1'b0, shifted} - {2'b00, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= 7'd64;
      q     <= numer;
      r     <= '0;
      dv    <= denom;
    end else if (busy) begin
      if (!diff[33]) begin
        r <= diff[32:0];
        q <= {q[62:0], 1'b1};
      end else begin
        r <= shifted;
        q <= {q[62:0], 1'b0};
      end
      count <= count - 7'd1;
      busy  <= (count != 7'd1);
      done  <= (count == 7'd1);
    end else begin
      done <= 1'b0;
    end
  end

  assign quot = q;
  assign rem  = r[31:0];
endmodule

// ===== rtl/core/x86_integer_alu_with_flags_core.sv =====
// Integer ALU core: add/sub family with CF/ZF/SF/OF, multiply and divide.
// Every instruction takes an operand, runs in a sequencer and returns one
// result word. An add or subtract family instruction goes from the execute
// state to the output state; a multiply passes through a multiply state, a
// divide by zero through a fault state, and a divide waits on the 64-step
// shift-subtract divider (operands are sized to a 64-bit numerator). The
// result is held until out_ready. The input is not ready while an item is
// in flight; the flags reset to zero. Depends on xalu_pkg and xalu_divider.
module x86_integer_alu_with_flags_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  xalu_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output xalu_pkg::out_word_t out_word
);
  import xalu_pkg::*;
  `include "x86_integer_alu_with_flags_core_assert.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIVW = 3'd3;
  localparam logic [2:0] ST_DIVF = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]  state;
  in_word_t    op;
  logic [3:0]  flags;  // bit0 CF, bit1 ZF, bit2 SF, bit3 OF
  out_word_t   res;
  logic [31:0] m, d, s, a;
  logic [63:0] prod;
  logic        nneg, dneg;
  logic [63:0] numer, nm;
  logic [31:0] dm;
  logic        dv_start, dv_busy, dv_done;
  logic [63:0] dv_q;
  logic [31:0] dv_r;

  // Operands masked to operand size.
  always_comb begin
    m = size_mask(op.size_code);
    d = op.dest_value & m;
    s = op.src_value & m;
    a = op.acc_low & m;
  end

  // Divide operand preparation: magnitudes of numerator and divisor.
  always_comb begin
    unique case (op.size_code)
      SIZE_BYTE: numer = {48'd0, op.acc_low[15:0]};
      SIZE_WORD: numer = {32'd0, op.acc_high[15:0], op.acc_low[15:0]};
      default:   numer = {op.acc_high, op.acc_low};
    endcase
    unique case (op.size_code)
      SIZE_BYTE: nneg = (op.cmd == CMD_IDIV) && numer[15];
      SIZE_WORD: nneg = (op.cmd == CMD_IDIV) && numer[31];
      default:   nneg = (op.cmd == CMD_IDIV) && numer[63];
    endcase
    dneg = (op.cmd == CMD_IDIV) && size_msb(d, op.size_code);
    nm   = nneg ? (64'd0 - numer) : numer;
    unique case (op.size_code)
      SIZE_BYTE: nm = nm & 64'hFFFF;
      SIZE_WORD: nm = nm & 64'hFFFF_FFFF;
      default:   nm = nm;
    endcase
    dm = dneg ? ((32'd0 - d) & m) : d;
  end

  assign dv_start = (state == ST_EXEC) && (op.cmd == CMD_DIV || op.cmd == CMD_IDIV)
                    && (dm != 32'd0);

  xalu_divider u_div (
    .clk(clk), .rst(rst), .start(dv_start), .numer(nm), .denom(dm),
    .busy(dv_busy), .done(dv_done), .quot(dv_q), .rem(dv_r)
  );

  // Add/sub family sum from the shared adder, and the multiplier product.
  logic [32:0] sum;
  logic [31:0] lo, half;
  logic [31:0] sxd, sxo;
  logic        cf;
  logic [32:0] ma, mb;
  logic signed [65:0] mprod;
  always_comb begin
    cf   = flags[0];
    half = m >> 1;
    sum  = 33'd0;
    unique case (op.cmd)
      CMD_ADD, CMD_ADC: sum = {1'b0, d} + {1'b0, s}
                              + {32'd0, (op.cmd == CMD_ADC) & cf};
      CMD_SUB, CMD_CMP, CMD_SBB: begin
        sum = {1'b0, d} - {1'b0, s} - {32'd0, (op.cmd == CMD_SBB) & cf};
      end
      CMD_INC: sum = {1'b0, d} + 33'd1;
      CMD_DEC: sum = {1'b0, d} - 33'd1;
      CMD_NEG: sum = 33'd0 - {1'b0, d};
      default: sum = 33'd0;
    endcase
    lo = sum[31:0] & m;
    // Sign-extended multiply operands.
    sxd = size_msb(d, op.size_code) ? (d | ~m) : d;
    sxo = (op.cmd == CMD_IMULT) ? (size_msb(s, op.size_code) ? (s | ~m) : s)
                                : (size_msb(a, op.size_code) ? (a | ~m) : a);
    // One 33-by-33 signed multiplier serves both unsigned and signed forms.
    ma    = (op.cmd == CMD_MUL) ? {1'b0, d} : {sxd[31], sxd};
    mb    = (op.cmd == CMD_MUL) ? {1'b0, a} : {sxo[31], sxo};
    mprod = $signed(ma) * $signed(mb);
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) prod <= mprod[63:0];
  end

  logic [63:0] prod_hi;
  logic [63:0] qlim;
  logic [63:0] q_out;
  logic [31:0] r_out;
  logic        qbad;
  always_comb begin
    unique case (op.size_code)
      SIZE_BYTE: prod_hi = prod >> 8;
      SIZE_WORD: prod_hi = prod >> 16;
      default:   prod_hi = prod >> 32;
    endcase
    if (op.cmd == CMD_DIV) qlim = {32'd0, m};
    else if (nneg != dneg) qlim = {32'd0, half} + 64'd1;
    else qlim = {32'd0, half};
    qbad  = dv_q > qlim;
    q_out = (nneg != dneg) ? (64'd0 - dv_q) : dv_q;
    r_out = nneg ? (32'd0 - dv_r) : dv_r;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      flags <= 4'd0;
    end else begin
      unique case (state)
        ST_IDLE: if (in_valid) begin
          op    <= in_word;
          res   <= '0;
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          unique case (op.cmd)
            CMD_ADD, CMD_ADC, CMD_SUB, CMD_CMP, CMD_SBB, CMD_INC, CMD_DEC,
            CMD_NEG: begin
              logic zf, sf, of, cn;
              zf = (lo == 32'd0);
              sf = size_msb(lo, op.size_code);
              cn = flags[0];
              of = 1'b0;
              unique case (op.cmd)
                CMD_ADD, CMD_ADC: begin
                  of = size_msb(~(d ^ s) & (d ^ lo), op.size_code);
                  cn = (op.size_code == SIZE_BYTE) ? sum[8] :
                       (op.size_code == SIZE_WORD) ? sum[16] : sum[32];
                end
                CMD_SUB, CMD_CMP, CMD_SBB: begin
                  of = size_msb((d ^ s) & (d ^ lo), op.size_code);
                  cn = ({1'b0, d} < ({1'b0, s} + {32'd0, (op.cmd == CMD_SBB) & cf}));
                end
                CMD_INC: of = (d == half);
                CMD_DEC: of = (d == half + 32'd1);
                default: begin
                  of = (d == half + 32'd1);
                  cn = (d != 32'd0);
                end
              endcase
              flags <= {of, sf, zf, cn};
              res.result_low    <= lo;
              res.write_back    <= (op.cmd != CMD_CMP);
              res.carry_flag    <= cn;
              res.zero_flag     <= zf;
              res.sign_flag     <= sf;
              res.overflow_flag <= of;
              state <= ST_OUT;
            end
            CMD_MUL, CMD_IMUL1, CMD_IMULT: state <= ST_MUL;
            CMD_DIV, CMD_IDIV: state <= (dm == 32'd0) ? ST_DIVF : ST_DIVW;
            default: begin
              res.carry_flag    <= flags[0];
              res.zero_flag     <= flags[1];
              res.sign_flag     <= flags[2];
              res.overflow_flag <= flags[3];
              state <= ST_OUT;
            end
          endcase
        end
        ST_MUL: begin
          res.result_low    <= prod[31:0] & m;
          res.result_high   <= (op.cmd == CMD_IMULT) ? 32'd0 : (prod_hi[31:0] & m);
          res.write_back    <= 1'b1;
          res.high_valid    <= (op.cmd != CMD_IMULT);
          res.carry_flag    <= flags[0];
          res.zero_flag     <= flags[1];
          res.sign_flag     <= flags[2];
          res.overflow_flag <= flags[3];
          state <= ST_OUT;
        end
        ST_DIVW: if (dv_done) begin
          res.carry_flag    <= flags[0];
          res.zero_flag     <= flags[1];
          res.sign_flag     <= flags[2];
          res.overflow_flag <= flags[3];
          if (qbad) begin
            res.divide_fault <= 1'b1;
          end else begin
            res.result_low  <= q_out[31:0] & m;
            res.result_high <= r_out & m;
            res.write_back  <= 1'b1;
            res.high_valid  <= 1'b1;
          end
          state <= ST_OUT;
        end
        ST_DIVF: begin
          res.carry_flag    <= flags[0];
          res.zero_flag     <= flags[1];
          res.sign_flag     <= flags[2];
          res.overflow_flag <= flags[3];
          res.divide_fault  <= 1'b1;
          state <= ST_OUT;
        end
        ST_OUT: if (out_ready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign out_word  = res;

  `XALU_ASSERT_IMP(a_div_quiet, dv_busy, state == ST_DIVW)
  `XALU_ASSERT_IMP(a_fault_nowb, out_valid && out_word.divide_fault,
                   !out_word.write_back && !out_word.high_valid)
  `XALU_ASSERT_NXT(a_out_from_done, state == ST_DIVW && dv_done, state == ST_OUT)
endmodule

// ===== dv/x86_integer_alu_with_flags_core_tb.sv =====
// Testbench for the x86 integer ALU core: directed and random instructions,
// with a flag-tracking predictor and an in-order scoreboard class.
// Depends on xalu_pkg and x86_integer_alu_with_flags_core.
`timescale 1ns / 100ps

module x86_integer_alu_with_flags_core_tb;
  import xalu_pkg::*;

  // Command code that the block does not implement.
  localparam logic [3:0] CMD_UNUSED = 4'd15;

  // Predicts ALU results and holds the words still owed by the block.
  class alu_scoreboard;
    logic [3:0]  flags;  // bit0 CF, bit1 ZF, bit2 SF, bit3 OF
    out_word_t   pending[$];
    int          errors;

    function new();
      flags = '0;
      errors = 0;
    endfunction

    // Computes the result of one instruction and queues it.
    function void note_input(in_word_t w);
      out_word_t   r;
      int          wd;
      logic [63:0] m, d, s, sum, b, res, n, m2, nm, dm, q, rem, ov;
      logic        cf, nneg, dneg;
      longint      sp;
      r = '0;
      wd = (w.size_code == SIZE_BYTE) ? 8 : (w.size_code == SIZE_WORD) ? 16 : 32;
      m = (64'd1 << wd) - 1;
      d = w.dest_value & m;
      s = w.src_value & m;
      cf = flags[0];
      case (w.cmd)
        CMD_ADD, CMD_ADC: begin
          sum = d + s + ((w.cmd == CMD_ADC) ? cf : 1'b0);
          res = sum & m;
          r.write_back = 1;
          set_zs(res, wd);
          flags[0] = sum[wd];
          ov = ~(d ^ s) & (d ^ res);
          flags[3] = ov[wd - 1];
        end
        CMD_SUB, CMD_CMP, CMD_SBB: begin
          b = s + ((w.cmd == CMD_SBB) ? cf : 1'b0);
          res = (d - b) & m;
          r.write_back = (w.cmd != CMD_CMP);
          set_zs(res, wd);
          flags[0] = d < b;
          ov = (d ^ s) & (d ^ res);
          flags[3] = ov[wd - 1];
        end
        CMD_INC: begin
          res = (d + 1) & m;
          r.write_back = 1;
          set_zs(res, wd);
          flags[3] = d == (m >> 1);
        end
        CMD_DEC: begin
          res = (d - 1) & m;
          r.write_back = 1;
          set_zs(res, wd);
          flags[3] = d == (m >> 1) + 1;
        end
        CMD_NEG: begin
          res = (-d) & m;
          r.write_back = 1;
          set_zs(res, wd);
          flags[0] = d != 0;
          flags[3] = d == (m >> 1) + 1;
        end
        CMD_MUL: begin
          sum = d * (w.acc_low & m);
          res = sum & m;
          r.result_high = 32'((sum >> wd) & m);
          r.write_back = 1;
          r.high_valid = 1;
        end
        CMD_IMUL1, CMD_IMULT: begin
          sp = sext(d, wd) * sext((w.cmd == CMD_IMUL1) ? w.acc_low : s, wd);
          res = sp & m;
          if (w.cmd == CMD_IMUL1) begin
            r.result_high = 32'((sp >> wd) & m);
            r.high_valid = 1;
          end
          r.write_back = 1;
        end
        CMD_DIV, CMD_IDIV: begin
          res = 0;
          m2 = (wd == 32) ? '1 : (64'd1 << (2 * wd)) - 1;
          if (wd == 8) n = w.acc_low & 64'hFFFF;
          else n = ((64'(w.acc_high) << wd) | (w.acc_low & m)) & m2;
          nneg = (w.cmd == CMD_IDIV) && n[2 * wd - 1];
          dneg = (w.cmd == CMD_IDIV) && d[wd - 1];
          nm = nneg ? (-n) & m2 : n;
          dm = dneg ? (-d) & m : d;
          if (dm == 0) r.divide_fault = 1;
          else begin
            q = nm / dm;
            rem = nm % dm;
            if (w.cmd == CMD_DIV) r.divide_fault = q > m;
            else if (nneg != dneg) begin
              r.divide_fault = q > (m >> 1) + 1;
              q = -q;
            end else r.divide_fault = q > (m >> 1);
            if (!r.divide_fault) begin
              if (nneg) rem = -rem;
              res = q & m;
              r.result_high = 32'(rem & m);
              r.write_back = 1;
              r.high_valid = 1;
            end
          end
        end
        default: res = 0;
      endcase
      r.result_low = res[31:0];
      {r.overflow_flag, r.sign_flag, r.zero_flag, r.carry_flag} = flags;
      pending.push_back(r);
    endfunction

    function void set_zs(logic [63:0] v, int wd);
      flags[1] = (v & ((64'd1 << wd) - 1)) == 0;
      flags[2] = v[wd - 1];
    endfunction

    function longint sext(logic [63:0] v, int wd);
      v = v & ((64'd1 << wd) - 1);
      return v[wd - 1] ? longint'(v) - (longint'(1) << wd) : longint'(v);
    endfunction

    // Compares one result word with the oldest prediction.
    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w) begin
        $display("%0t: mismatch expected lo=%h hi=%h wb=%b hv=%b f=%b%b%b%b df=%b",
                 $time, exp_w.result_low, exp_w.result_high, exp_w.write_back,
                 exp_w.high_valid, exp_w.carry_flag, exp_w.zero_flag,
                 exp_w.sign_flag, exp_w.overflow_flag, exp_w.divide_fault);
        $display("%0t:          actual   lo=%h hi=%h wb=%b hv=%b f=%b%b%b%b df=%b",
                 $time, got.result_low, got.result_high, got.write_back,
                 got.high_valid, got.carry_flag, got.zero_flag,
                 got.sign_flag, got.overflow_flag, got.divide_fault);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 0;
  out_word_t out_word;

  alu_scoreboard sb = new();
  int send_idle_pct;
  int recv_idle_pct;
  longint cycles;

  x86_integer_alu_with_flags_core i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_word(in_word), .out_valid(out_valid), .out_ready(out_ready),
    .out_word(out_word)
  );

  always #6 clk = ~clk;

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: random stalls, checks every accepted word.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_word);
    out_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // Sends one instruction, with a random gap before it. Valid stays high
  // from one word to the next when there is no gap.
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
  endtask

  task automatic send_op(logic [3:0] c, logic [1:0] sz, logic [31:0] d, logic [31:0] s,
                         logic [31:0] al, logic [31:0] ah);
    in_word_t w;
    w.cmd = c;
    w.size_code = sz;
    w.dest_value = d;
    w.src_value = s;
    w.acc_low = al;
    w.acc_high = ah;
    send_word(w);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return {24'($urandom), 8'h80 ^ 8'($urandom_range(1))};
      3: return 32'($urandom_range(3));
      default: return $urandom;
    endcase
  endfunction

  // Random instruction; divides are mostly shaped to avoid a fault.
  task automatic send_random();
    logic [3:0]  c;
    logic [1:0]  sz;
    logic [31:0] d, ah;
    c = ($urandom_range(19) == 0) ? 4'($urandom_range(13, 15)) : 4'($urandom_range(12));
    sz = 2'($urandom_range(3));
    d = pick_value();
    ah = pick_value();
    if ((c == CMD_DIV || c == CMD_IDIV) && $urandom_range(3) != 0) begin
      ah = $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
      d = d | 32'h0000_0001;
    end
    send_op(c, sz, d, pick_value(), pick_value(), ah);
  endtask

  // Drops valid and waits until every predicted word has come back.
  task automatic wait_drained();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    cycles = 0;
    send_idle_pct = 13;
    recv_idle_pct = 62;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: operand extremes, every command, flag special cases.
    send_op(CMD_ADD, SIZE_BYTE, 32'hFF, 32'h01, 0, 0);
    send_op(CMD_ADC, SIZE_BYTE, 32'h7F, 32'h00, 0, 0);
    send_op(CMD_INC, SIZE_WORD, 32'h7FFF, 0, 0, 0);
    send_op(CMD_DEC, SIZE_DWORD, 32'h8000_0000, 0, 0, 0);
    send_op(CMD_CMP, SIZE_DWORD, 32'h0, 32'hFFFF_FFFF, 0, 0);
    send_op(CMD_SBB, SIZE_WORD, 32'h0, 32'h0, 0, 0);
    send_op(CMD_SUB, SIZE_BYTE, 32'h80, 32'h01, 0, 0);
    send_op(CMD_NEG, SIZE_BYTE, 32'h80, 0, 0, 0);
    send_op(CMD_NEG, SIZE_DWORD, 32'h0, 0, 0, 0);
    send_op(CMD_MUL, SIZE_DWORD, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0);
    send_op(CMD_IMUL1, SIZE_WORD, 32'h8000, 0, 32'h8000, 0);
    send_op(CMD_IMULT, SIZE_BYTE, 32'hFF, 32'h7F, 0, 0);
    send_op(CMD_DIV, SIZE_DWORD, 32'h0, 0, 32'h1234, 0);
    send_op(CMD_DIV, SIZE_BYTE, 32'h01, 0, 32'h0100, 0);
    send_op(CMD_DIV, SIZE_RSVD, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_op(CMD_IDIV, SIZE_BYTE, 32'hFF, 0, 32'hFF80, 0);
    send_op(CMD_IDIV, SIZE_WORD, 32'hFFFF, 0, 32'h8000, 32'hFFFF);
    send_op(CMD_IDIV, SIZE_DWORD, 32'hFFFF_FFFF, 0, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(CMD_IDIV, SIZE_DWORD, 32'h7, 0, 32'hFFFF_FFF9, 32'hFFFF_FFFF);
    send_op(CMD_UNUSED, SIZE_BYTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF);

    // Sender holds off until the block has returned every word.
    wait_drained();

    for (int i = 0; i < 400; i++) send_random();
    send_idle_pct = 62;
    recv_idle_pct = 13;
    for (int i = 0; i < 400; i++) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 400; i++) send_random();

    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
